/* hdl/ssir_pkg.sv */
`default_nettype none

package ssir_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_LISTED    = 3'd6;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry_value;
    logic [4:0]         entry_count;
    logic               last;
  } out_item_t;

  // Classified request as held in the queue
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } req_t;

endpackage

`default_nettype wire

/* hdl/ssir_front.sv */
`default_nettype none

module ssir_front import ssir_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          push,
  output req_t          push_req,
  input  wire logic     q_full
);

  logic f_valid;
  req_t f_req;
  logic accept;
  logic op_known;

  // Stall only while the holding register cannot drain into the queue
  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !q_full;
  assign push_req = f_req;

  // Undefined op codes are dropped here and never reach the back end
  always_comb begin
    case (in_item.op)
      OP_INSERT, OP_REMOVE, OP_LIST: op_known = 1'b1;
      default:                       op_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= op_known;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_req.op    <= in_item.op;
      f_req.value <= in_item.value;
    end
  end

endmodule

`default_nettype wire

/* hdl/ssir_queue.sv */
`default_nettype none

module ssir_queue import ssir_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t push_req,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output req_t      rd_req
);

  req_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full   = (fill == QCNT_W'(QDEPTH));
  assign valid  = (fill != '0);
  assign rd_req = slots[rd_ptr];

  // Pointer and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

`default_nettype wire

/* hdl/ssir_back.sv */
`default_nettype none

module ssir_back import ssir_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire req_t  q_req,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_item,
  output logic [CNT_W-1:0] count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_LIST = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  req_t                cur;
  logic signed [31:0]  cells [CAPACITY];
  logic signed [31:0]  up    [CAPACITY];
  logic signed [31:0]  dn    [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] lt_c;
  logic [CAPACITY-1:0] eq_c;
  logic [CAPACITY-1:0] slot;
  logic [CNT_W-1:0]    count_next;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    idx_next;
  logic                can_emit;
  logic                emit;
  logic                done;
  logic                do_ins;
  logic                do_rem;
  out_item_t           emit_item;

  assign can_emit = !out_valid || !out_stall;

  // Compare row: every live cell against the operand
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_c[i] = (CNT_W'(i) < count) && (cells[i] < cur.value);
      eq_c[i] = (CNT_W'(i) < count) && (cells[i] == cur.value);
    end
  end

  // Neighbor taps for the shift; slot marks the cell that takes a new value
  always_comb begin
    up[0]            = cur.value;
    dn[CAPACITY-1]   = cells[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      up[i]   = cells[i-1];
      dn[i-1] = cells[i];
    end
  end
  assign slot = {lt[CAPACITY-2:0], 1'b1};

  // Sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    pop        = 1'b0;
    emit       = 1'b0;
    done       = 1'b0;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    emit_item  = '0;
    emit_item.entry_value = cur.value;
    emit_item.last        = 1'b1;

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (can_emit) begin
          emit = 1'b1;
          done = 1'b1;
          case (cur.op)
            OP_INSERT: begin
              if (|eq) begin
                emit_item.status = ST_DUPLICATE;
              end else if (count >= CNT_W'(CAPACITY)) begin
                emit_item.status = ST_FULL;
              end else begin
                do_ins           = 1'b1;
                count_next       = count + 1'b1;
                emit_item.status = ST_INSERTED;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                emit_item.status = ST_EMPTY;
              end else if (!(|eq)) begin
                emit_item.status = ST_NOTFOUND;
              end else begin
                do_rem           = 1'b1;
                count_next       = count - 1'b1;
                emit_item.status = ST_REMOVED;
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                emit_item.status = ST_EMPTY;
              end else begin
                // first entry goes out now, the rest stream from S_LIST
                emit_item.status      = ST_LISTED;
                emit_item.entry_value = cells[0];
                emit_item.last        = (count == CNT_W'(1));
                if (count != CNT_W'(1)) begin
                  done       = 1'b0;
                  idx_next   = IDX_W'(1);
                  state_next = S_LIST;
                end
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_LIST: begin
        if (can_emit) begin
          emit                  = 1'b1;
          emit_item.status      = ST_LISTED;
          emit_item.entry_value = cells[idx];
          emit_item.last        = (CNT_W'(idx) + CNT_W'(1) == count);
          if (emit_item.last) begin
            done = 1'b1;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    emit_item.entry_count = 5'(count_next);

    // Chain straight into the next request when one is waiting
    if (done) begin
      if (q_valid) begin
        pop        = 1'b1;
        state_next = S_CMP;
      end else begin
        state_next = S_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request, compare flags and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_req;
    end
    if (state == S_CMP) begin
      lt <= lt_c;
      eq <= eq_c;
    end
    if (emit) begin
      out_item <= emit_item;
    end
  end

  // Cell row: insert opens a gap at the slot, remove closes over the match
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_ins && !lt[i]) begin
        cells[i] <= slot[i] ? cur.value : up[i];
      end else if (do_rem && !lt[i]) begin
        cells[i] <= dn[i];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/sorted_set_insert_remove_core.sv */
// Sorted set of signed 32-bit values, up to CAPACITY entries, kept in
// ascending order. A request is insert, remove or list; undefined op codes
// are dropped with no result. Insert and remove give one result each; list
// gives one result per stored entry in ascending order (one empty result on an
// empty store), with last set on the final one. Requests pass through a
// holding register and a two-entry queue into the execution side, which
// handles each request with a registered compare row followed by an apply
// step, and streams a list one entry a cycle, whenever the output is not
// stalled.
`default_nettype none

module sorted_set_insert_remove_core import ssir_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic             q_push;
  req_t             q_push_req;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  req_t             q_req;
  logic [CNT_W-1:0] count;

  ssir_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (q_push),
    .push_req (q_push_req),
    .q_full   (q_full)
  );

  ssir_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (q_push_req),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .rd_req   (q_req)
  );

  ssir_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .count     (count)
  );

`ifndef SYNTHESIS
  // Store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Only list streams carry non-final results
  a_nonlast_listed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |-> out_item.status == ST_LISTED)
    else $error("non-final result outside a list");

  // Front never pushes into a full queue, back never pops an empty one
  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full) && !(q_pop && !q_valid))
    else $error("queue overflow or underflow");

  // A successful insert reports the store's entry count after the insert
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_item.status == ST_INSERTED |->
      out_item.entry_count == 5'(count))
    else $error("insert result count mismatch");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssir_pkg::*;

  // Op code the block drops without any result
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;
  localparam int POOL_SIZE = 24;

  // Sorted-set predictor plus the queue of results it expects
  class sorted_set_scoreboard;
    logic signed [31:0] entries [CAPACITY];
    int unsigned        count = 0;
    out_item_t          expected_q [$];
    int                 errors = 0;
    int                 results_seen = 0;
    int                 full_rejects = 0;
    int                 op_seen [4] = '{0, 0, 0, 0};

    function void push_result(logic [2:0] status, logic signed [31:0] value, logic last);
      out_item_t r;
      r.status      = status;
      r.entry_value = value;
      r.entry_count = count[4:0];
      r.last        = last;
      expected_q.push_back(r);
    endfunction

    // Apply one accepted request to the model and queue its results
    function void note_request(in_item_t req);
      int unsigned pos;
      op_seen[req.op]++;
      case (req.op)
        OP_INSERT: begin
          pos = 0;
          while (pos < count && entries[pos] < req.value) pos++;
          if (pos < count && entries[pos] == req.value) begin
            push_result(ST_DUPLICATE, req.value, 1'b1);
          end else if (count >= CAPACITY) begin
            full_rejects++;
            push_result(ST_FULL, req.value, 1'b1);
          end else begin
            for (int i = count; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = req.value;
            count++;
            push_result(ST_INSERTED, req.value, 1'b1);
          end
        end
        OP_REMOVE: begin
          if (count == 0) begin
            push_result(ST_EMPTY, req.value, 1'b1);
          end else begin
            pos = 0;
            while (pos < count && entries[pos] != req.value) pos++;
            if (pos >= count) begin
              push_result(ST_NOTFOUND, req.value, 1'b1);
            end else begin
              for (int i = pos; i + 1 < count; i++) entries[i] = entries[i+1];
              count--;
              push_result(ST_REMOVED, req.value, 1'b1);
            end
          end
        end
        OP_LIST: begin
          if (count == 0) begin
            push_result(ST_EMPTY, req.value, 1'b1);
          end else begin
            for (int i = 0; i < count; i++) push_result(ST_LISTED, entries[i], i + 1 == count);
          end
        end
        default: ;  // undefined op: no state change, no result
      endcase
    endfunction

    // Compare one output against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected result: status %0d entry_value %0d", got.status, got.entry_value);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
      if (got.entry_value !== want.entry_value) begin
        errors++;
        $error("entry_value: expected %0d, actual %0d", want.entry_value, got.entry_value);
      end
      if (got.entry_count !== want.entry_count) begin
        errors++;
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last: expected %0d, actual %0d", want.last, got.last);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  sorted_set_scoreboard book;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  bit                   hold_request;
  int                   cycle_count;
  logic signed [31:0]   value_pool [POOL_SIZE];

  sorted_set_insert_remove_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request, with an optional idle gap first; valid stays high after acceptance
  task automatic issue(input logic [1:0] op, input logic signed [31:0] value);
    in_item_t req;
    req.op    = op;
    req.value = value;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    book.note_request(req);
  endtask

  // Mostly values from a small pool so that hits and duplicates are common
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 70) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic random_requests(input int n, input int insert_pct);
    int         roll;
    logic [1:0] op;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 4) op = OP_UNDEFINED;
      else if (roll < 14) op = OP_LIST;
      else if (roll < 14 + insert_pct) op = OP_INSERT;
      else op = OP_REMOVE;
      issue(op, pick_value());
    end
  endtask

  // Result side: check accepted results, drive stall, honor a long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) book.check_result(out_item);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    int idle_set [4][2];
    idle_set = '{'{0, 0}, '{85, 0}, '{0, 85}, '{27, 27}};
    book           = new;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_item  <= '0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, extremes, duplicate, not found, fill, full, list
    issue(OP_LIST, 32'sh1234_5678);
    issue(OP_REMOVE, -32'sd7);
    issue(OP_UNDEFINED, 32'sd99);
    issue(OP_INSERT, 32'sh7fff_ffff);
    issue(OP_INSERT, 32'sh8000_0000);
    issue(OP_INSERT, 32'sd0);
    issue(OP_INSERT, -32'sd1);
    issue(OP_INSERT, 32'sd1);
    issue(OP_INSERT, 32'sd0);
    issue(OP_REMOVE, 32'sd5);
    issue(OP_LIST, 32'sd0);
    issue(OP_REMOVE, 32'sh8000_0000);
    for (int i = 0; i < 12; i++) issue(OP_INSERT, $urandom);
    issue(OP_INSERT, 32'sd42);
    issue(OP_INSERT, -32'sd1);
    issue(OP_LIST, 32'sd0);

    // Random phases with different idling on each side
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_set[p][0];
      recv_stall_pct = idle_set[p][1];
      random_requests(8, 65);
      random_requests(7, 25);
    end

    // Receiver holds off while requests keep coming, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    issue(OP_LIST, 32'sd0);
    random_requests(12, 50);

    // Last request was just accepted; drop valid before the next edge
    in_valid <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Covered %0d inserts, %0d removes, %0d lists, %0d undefined ops; %0d results checked",
             book.op_seen[OP_INSERT], book.op_seen[OP_REMOVE], book.op_seen[OP_LIST],
             book.op_seen[OP_UNDEFINED], book.results_seen);
    $display("Inserts refused on a full store: %0d; mismatches: %0d",
             book.full_rejects, book.errors);
    if (book.errors == 0 && book.expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
